// ----- rtl/mexp_pkg.sv -----
`default_nettype none

package mexp_pkg;

  // Field widths
  localparam int BASE_W = 63;
  localparam int EXP_W  = 63;
  localparam int MOD_W  = 31;

  // Reduction unit: dividend width and bits retired per cycle
  localparam int DVD_W      = 64;
  localparam int RED_STEP   = 4;
  localparam int RED_CYCLES = DVD_W / RED_STEP;
  localparam int RED_CNT_W  = $clog2(RED_CYCLES);

  localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;

  // Reduction unit operation: reduce a loaded value or a product
  typedef enum logic {
    RED_LOAD,
    RED_MUL
  } red_op_e;

  typedef struct packed {
    logic    start;
    red_op_e op;
  } red_cmd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_BASE,
    S_STEP,
    S_ACC,
    S_SQR
  } mexp_state_e;

endpackage

`default_nettype wire

// ----- rtl/mexp_reduce.sv -----
`default_nettype none

// Shared multiply-reduce unit: one 31x31 product (or a loaded value) is
// registered, then reduced modulo mod_i, RED_STEP dividend bits per cycle.
module mexp_reduce
  import mexp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire red_cmd_t          cmd_i,
  input  wire logic [BASE_W-1:0] load_i,
  input  wire logic [MOD_W-1:0]  a_i,
  input  wire logic [MOD_W-1:0]  b_i,
  input  wire logic [MOD_W-1:0]  mod_i,
  output logic      [MOD_W-1:0]  rem_o,
  output logic                   done_o
);

  logic [DVD_W-1:0]     dvd_q, dvd_d;
  logic [MOD_W:0]       rem_q, rem_d;
  logic [RED_CNT_W-1:0] cnt_q;
  logic                 run_q;
  logic                 done_q;
  logic [2*MOD_W-1:0]   prod;
  logic [MOD_W:0]       mod_ext;

  assign prod    = {{MOD_W{1'b0}}, a_i} * {{MOD_W{1'b0}}, b_i};
  assign mod_ext = {1'b0, mod_i};

  // Restoring remainder steps, one dividend bit each
  always_comb begin
    dvd_d = dvd_q;
    rem_d = rem_q;
    for (int k = 0; k < RED_STEP; k++) begin
      rem_d = {rem_d[MOD_W-1:0], dvd_d[DVD_W-1]};
      dvd_d = {dvd_d[DVD_W-2:0], 1'b0};
      if (rem_d >= mod_ext) begin
        rem_d = rem_d - mod_ext;
      end
    end
  end

  // Operand and remainder registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      if (cmd_i.op == RED_MUL) begin
        dvd_q <= {{(DVD_W-2*MOD_W){1'b0}}, prod};
      end else begin
        dvd_q <= {{(DVD_W-BASE_W){1'b0}}, load_i};
      end
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  // Iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == RED_CNT_W'(RED_CYCLES - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rem_o  = rem_q[MOD_W-1:0];
  assign done_o = done_q;

endmodule

`default_nettype wire

// ----- rtl/modular_exponentiation_top.sv -----
`default_nettype none

// Sequence: the base is reduced first, then each scanned exponent bit takes a square
// (bit clear) or a multiply and a square (bit set); the scan stops at the highest set bit.
// Each step runs on the shared multiply-reduce unit (one product, then 4 remainder
// bits a cycle); a base reducing to zero ends with a zero result after the base step.
// Throughput: one transaction at a time; busy_o falls as done_o rises; no receiver stall.
// Reset: asynchronous, active low; the modulus returns to 1000000007.
module modular_exponentiation_top
  import mexp_pkg::*;
#(
  parameter int EXP_BITS = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [BASE_W-1:0] base_i,
  input  wire logic [EXP_W-1:0]  exponent_i,
  output logic                   done_o,
  output logic      [MOD_W-1:0]  power_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [MOD_W-1:0]  cfg_modulus_i
);

  // Exponent bits at or above EXP_BITS are not scanned
  localparam int ScanBits = (EXP_BITS > EXP_W) ? EXP_W : EXP_BITS;
  localparam logic [EXP_W-1:0] ExpMask = {EXP_W{1'b1}} >> (EXP_W - ScanBits);

  mexp_state_e      state_q, state_d;
  logic [MOD_W-1:0] modulus_q;
  logic [MOD_W-1:0] mod_eff;
  logic [EXP_W-1:0] exp_q, exp_d;
  logic [MOD_W-1:0] acc_q, acc_d;
  logic [MOD_W-1:0] sq_q, sq_d;
  logic [MOD_W-1:0] power_q, power_d;
  logic             done_q, done_d;
  logic             accept;
  red_cmd_t         red_cmd;
  logic             sel_acc;
  logic [MOD_W-1:0] red_a;
  logic [MOD_W-1:0] red_rem;
  logic             red_done;

  assign accept = start_i && (state_q == S_IDLE);

  // Modulus register; zero acts as one
  assign cfg_ready_o = 1'b1;
  assign mod_eff     = (modulus_q == '0) ? MOD_W'(1) : modulus_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MOD_RESET;
    end else if (cfg_valid_i) begin
      modulus_q <= cfg_modulus_i;
    end
  end

  // Shared multiply-reduce unit
  assign red_a = sel_acc ? acc_q : sq_q;

  mexp_reduce u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (red_cmd),
    .load_i (base_i),
    .a_i    (red_a),
    .b_i    (sq_q),
    .mod_i  (mod_eff),
    .rem_o  (red_rem),
    .done_o (red_done)
  );

  // Sequencer: next state and datapath control
  always_comb begin
    state_d       = state_q;
    exp_d         = exp_q;
    acc_d         = acc_q;
    sq_d          = sq_q;
    power_d       = power_q;
    done_d        = 1'b0;
    red_cmd.start = 1'b0;
    red_cmd.op    = RED_MUL;
    sel_acc       = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          exp_d         = exponent_i & ExpMask;
          red_cmd.start = 1'b1;
          red_cmd.op    = RED_LOAD;
          state_d       = S_BASE;
        end
      end
      S_BASE: begin
        if (red_done) begin
          sq_d  = red_rem;
          acc_d = MOD_W'(1);
          if (red_rem == '0) begin
            power_d = '0;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_STEP;
          end
        end
      end
      S_STEP: begin
        if (exp_q == '0) begin
          power_d = acc_q;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (exp_q[0]) begin
          sel_acc       = 1'b1;
          red_cmd.start = 1'b1;
          state_d       = S_ACC;
        end else begin
          red_cmd.start = 1'b1;
          state_d       = S_SQR;
        end
      end
      S_ACC: begin
        if (red_done) begin
          acc_d = red_rem;
          // last set bit: the remaining square is not needed
          if (exp_q[EXP_W-1:1] == '0) begin
            power_d = red_rem;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            red_cmd.start = 1'b1;
            state_d       = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (red_done) begin
          sq_d    = red_rem;
          exp_d   = exp_q >> 1;
          state_d = S_STEP;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    exp_q   <= exp_d;
    acc_q   <= acc_d;
    sq_q    <= sq_d;
    power_q <= power_d;
  end

  assign busy_o  = (state_q != S_IDLE);
  assign done_o  = done_q;
  assign power_o = power_q;

endmodule

`default_nettype wire
